@@ sv/sm83_pkg.sv @@
// ----------------------------------------------------------------------------
// sm83_pkg
// Shared types and constants for the SM83 instruction execute subset block.
// ----------------------------------------------------------------------------
package sm83_pkg;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [15:0] immediate;
    logic [7:0]  bus_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] reg_af;
    logic [15:0] reg_bc;
    logic [15:0] reg_de;
    logic [15:0] reg_hl;
    logic [15:0] reg_sp;
    logic [15:0] reg_pc;
    logic [15:0] mem_addr;
    logic        mem_read;
    logic        mem_write;
    logic [7:0]  write_data;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LD16_IMM,
    OP_ST_IND,
    OP_LD_IND,
    OP_INC16,
    OP_DEC16,
    OP_ADD_HL,
    OP_INC8,
    OP_DEC8,
    OP_LD8_IMM,
    OP_LD8_REG
  } op_class_e;

  // Decoded instruction handed from the front end to the execute stage.
  typedef struct packed {
    op_class_e   op_class;
    logic [1:0]  rp;
    logic [2:0]  rd;
    logic [2:0]  rs;
    logic [15:0] immediate;
    logic [7:0]  bus_data;
  } dec_item_t;

  localparam int unsigned QueueDepth = 2;
  localparam logic [2:0] R8Mem = 3'd6;
  localparam logic [2:0] R8Acc = 3'd7;

endpackage

@@ sv/sm83_cpu_execute_subset_top.sv @@
// ----------------------------------------------------------------------------
// sm83_cpu_execute_subset_top
// Executes a subset of SM83 instructions, one result per instruction.
// ----------------------------------------------------------------------------
// Usage: the input side is a queue. A transaction carrying opcode, immediate
// bytes and the bus byte is taken on a rising edge with push high and
// full low. Each instruction is decoded in the same cycle and placed in a
// two-entry queue. The execute stage pulls one entry per cycle unless its
// result register is held, updates the register file and loads the result
// register, so a result passes through a queue entry and then the result
// register before it reaches the result ports.
// The result side is also a queue: while empty is low, the oldest result
// is on res_o and is taken on an edge with pop high.
// Throughput is one instruction per cycle while results are popped; the
// register file update in the execute stage sets that rate. A new result
// can be loaded in the same cycle the previous one is popped.
// When the receiver stalls, the result register holds, the queue fills and
// full rises after two more transactions.
// Reset clears all CPU registers to zero and empties both queues.
module sm83_cpu_execute_subset_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  sm83_pkg::in_item_t  data_i,
  output logic                empty,
  input  logic                pop,
  output sm83_pkg::out_item_t res_o
);

  sm83_pkg::dec_item_t dec, q_data;
  logic q_empty, take;

  sm83_decode u_decode (
    .item_i (data_i),
    .dec_o  (dec)
  );

  sm83_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (dec),
    .full_o  (full),
    .pop_i   (take),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  sm83_execute u_execute (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (!q_empty),
    .dec_i   (q_data),
    .take_o  (take),
    .res_o   (res_o),
    .empty_o (empty),
    .pop_i   (pop)
  );

endmodule

@@ sv/sm83_decode.sv @@
// ----------------------------------------------------------------------------
// sm83_decode
// Front end: classifies an opcode into an instruction class and operands.
// ----------------------------------------------------------------------------
module sm83_decode (
  input  sm83_pkg::in_item_t  item_i,
  output sm83_pkg::dec_item_t dec_o
);

  logic [7:0] op;
  assign op = item_i.opcode;

  always_comb begin
    dec_o.op_class  = sm83_pkg::OP_NOP;
    dec_o.rp        = op[5:4];
    dec_o.rd        = op[5:3];
    dec_o.rs        = op[2:0];
    dec_o.immediate = item_i.immediate;
    dec_o.bus_data  = item_i.bus_data;
    if (op[7:6] == 2'b00) begin
      if      ((op & 8'hCF) == 8'h01) dec_o.op_class = sm83_pkg::OP_LD16_IMM;
      else if ((op & 8'hCF) == 8'h02) dec_o.op_class = sm83_pkg::OP_ST_IND;
      else if ((op & 8'hCF) == 8'h0A) dec_o.op_class = sm83_pkg::OP_LD_IND;
      else if ((op & 8'hCF) == 8'h03) dec_o.op_class = sm83_pkg::OP_INC16;
      else if ((op & 8'hCF) == 8'h0B) dec_o.op_class = sm83_pkg::OP_DEC16;
      else if ((op & 8'hCF) == 8'h09) dec_o.op_class = sm83_pkg::OP_ADD_HL;
      else if ((op & 8'hC7) == 8'h04) dec_o.op_class = sm83_pkg::OP_INC8;
      else if ((op & 8'hC7) == 8'h05) dec_o.op_class = sm83_pkg::OP_DEC8;
      else if ((op & 8'hC7) == 8'h06) dec_o.op_class = sm83_pkg::OP_LD8_IMM;
    end else if (op[7:6] == 2'b01 && op != 8'h76) begin
      dec_o.op_class = sm83_pkg::OP_LD8_REG;
    end
  end

endmodule

@@ sv/sm83_queue.sv @@
// ----------------------------------------------------------------------------
// sm83_queue
// Small FIFO of decoded instructions between front end and execute stage.
// ----------------------------------------------------------------------------
module sm83_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sm83_pkg::dec_item_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output sm83_pkg::dec_item_t data_o,
  output logic                empty_o
);

  localparam int unsigned AW = $clog2(sm83_pkg::QueueDepth);

  sm83_pkg::dec_item_t mem_q [sm83_pkg::QueueDepth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(sm83_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == AW'(sm83_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == AW'(sm83_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ sv/sm83_execute.sv @@
// ----------------------------------------------------------------------------
// sm83_execute
// Back end: holds the register file, executes one instruction per cycle while
// its output register is free or popped, and holds the result until popped.
// ----------------------------------------------------------------------------
module sm83_execute (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  sm83_pkg::dec_item_t  dec_i,
  output logic                 take_o,
  output sm83_pkg::out_item_t  res_o,
  output logic                 empty_o,
  input  logic                 pop_i
);

  logic [7:0]  a_q, a_d;
  logic [3:0]  f_q, f_d;
  logic [15:0] bc_q, bc_d, de_q, de_d, hl_q, hl_d, sp_q, sp_d, pc_q, pc_d;
  logic        full_q, full_d;
  sm83_pkg::out_item_t res_q, res_d;

  logic [15:0] r16_val, r16_new, addr;
  logic [7:0]  src8, r8_res;
  logic        rd_en, wr_en;
  logic [7:0]  wdata;
  logic [16:0] hl_sum;
  logic [12:0] h_sum;

  assign take_o  = valid_i && (!full_q || pop_i);
  assign empty_o = !full_q;
  assign res_o   = res_q;

  function automatic logic [7:0] r8_get(input logic [2:0] code, input logic [7:0] a,
                                        input logic [15:0] bc, input logic [15:0] de,
                                        input logic [15:0] hl, input logic [7:0] bus);
    logic [7:0] v;
    case (code)
      3'd0:    v = bc[15:8];
      3'd1:    v = bc[7:0];
      3'd2:    v = de[15:8];
      3'd3:    v = de[7:0];
      3'd4:    v = hl[15:8];
      3'd5:    v = hl[7:0];
      3'd6:    v = bus;
      default: v = a;
    endcase
    return v;
  endfunction

  always_comb begin
    a_d = a_q; f_d = f_q; bc_d = bc_q; de_d = de_q; hl_d = hl_q; sp_d = sp_q;
    pc_d   = pc_q + 16'd1;
    addr   = '0;
    rd_en  = 1'b0;
    wr_en  = 1'b0;
    wdata  = '0;
    src8   = '0;
    r8_res = '0;
    r16_new = '0;

    case (dec_i.rp)
      2'd0:    r16_val = bc_q;
      2'd1:    r16_val = de_q;
      2'd2:    r16_val = hl_q;
      default: r16_val = sp_q;
    endcase

    hl_sum = 17'(hl_q) + 17'(r16_val);
    h_sum  = 13'(hl_q[11:0]) + 13'(r16_val[11:0]);

    case (dec_i.op_class)
      sm83_pkg::OP_LD16_IMM: begin
        r16_new = dec_i.immediate;
        pc_d    = pc_q + 16'd3;
      end
      sm83_pkg::OP_INC16: r16_new = r16_val + 16'd1;
      sm83_pkg::OP_DEC16: r16_new = r16_val - 16'd1;
      sm83_pkg::OP_ST_IND, sm83_pkg::OP_LD_IND: begin
        case (dec_i.rp)
          2'd0:    addr = bc_q;
          2'd1:    addr = de_q;
          2'd2: begin
            addr = hl_q;
            hl_d = hl_q + 16'd1;
          end
          default: begin
            addr = hl_q;
            hl_d = hl_q - 16'd1;
          end
        endcase
        if (dec_i.op_class == sm83_pkg::OP_ST_IND) begin
          wr_en = 1'b1;
          wdata = a_q;
        end else begin
          rd_en = 1'b1;
          a_d   = dec_i.bus_data;
        end
      end
      sm83_pkg::OP_ADD_HL: begin
        hl_d = hl_sum[15:0];
        f_d  = {f_q[3], 1'b0, h_sum[12], hl_sum[16]};
      end
      sm83_pkg::OP_INC8, sm83_pkg::OP_DEC8: begin
        src8 = r8_get(dec_i.rd, a_q, bc_q, de_q, hl_q, dec_i.bus_data);
        if (dec_i.op_class == sm83_pkg::OP_INC8) begin
          r8_res = src8 + 8'd1;
          f_d = {r8_res == 8'd0, 1'b0, src8[3:0] == 4'hF, f_q[0]};
        end else begin
          r8_res = src8 - 8'd1;
          f_d = {r8_res == 8'd0, 1'b1, src8[3:0] == 4'h0, f_q[0]};
        end
      end
      sm83_pkg::OP_LD8_IMM: begin
        r8_res = dec_i.immediate[7:0];
        pc_d   = pc_q + 16'd2;
      end
      sm83_pkg::OP_LD8_REG: begin
        r8_res = r8_get(dec_i.rs, a_q, bc_q, de_q, hl_q, dec_i.bus_data);
      end
      default: ;
    endcase

    // Write back a 16-bit pair result.
    if (dec_i.op_class == sm83_pkg::OP_LD16_IMM || dec_i.op_class == sm83_pkg::OP_INC16 ||
        dec_i.op_class == sm83_pkg::OP_DEC16) begin
      case (dec_i.rp)
        2'd0:    bc_d = r16_new;
        2'd1:    de_d = r16_new;
        2'd2:    hl_d = r16_new;
        default: sp_d = r16_new;
      endcase
    end

    // Source read of [HL] for the 8-bit groups.
    if ((dec_i.op_class == sm83_pkg::OP_INC8 || dec_i.op_class == sm83_pkg::OP_DEC8) &&
        dec_i.rd == sm83_pkg::R8Mem) begin
      rd_en = 1'b1;
      addr  = hl_q;
    end
    if (dec_i.op_class == sm83_pkg::OP_LD8_REG && dec_i.rs == sm83_pkg::R8Mem) begin
      rd_en = 1'b1;
      addr  = hl_q;
    end

    // Write back an 8-bit result.
    if (dec_i.op_class == sm83_pkg::OP_INC8 || dec_i.op_class == sm83_pkg::OP_DEC8 ||
        dec_i.op_class == sm83_pkg::OP_LD8_IMM || dec_i.op_class == sm83_pkg::OP_LD8_REG) begin
      case (dec_i.rd)
        3'd0:    bc_d[15:8] = r8_res;
        3'd1:    bc_d[7:0]  = r8_res;
        3'd2:    de_d[15:8] = r8_res;
        3'd3:    de_d[7:0]  = r8_res;
        3'd4:    hl_d[15:8] = r8_res;
        3'd5:    hl_d[7:0]  = r8_res;
        sm83_pkg::R8Mem: begin
          wr_en = 1'b1;
          wdata = r8_res;
          addr  = hl_q;
        end
        default: a_d = r8_res;
      endcase
    end

    res_d.reg_af     = {a_d, f_d, 4'h0};
    res_d.reg_bc     = bc_d;
    res_d.reg_de     = de_d;
    res_d.reg_hl     = hl_d;
    res_d.reg_sp     = sp_d;
    res_d.reg_pc     = pc_d;
    res_d.mem_addr   = addr;
    res_d.mem_read   = rd_en;
    res_d.mem_write  = wr_en;
    res_d.write_data = wdata;

    full_d = take_o ? 1'b1 : (pop_i ? 1'b0 : full_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; f_q <= '0; bc_q <= '0; de_q <= '0; hl_q <= '0; sp_q <= '0; pc_q <= '0;
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
      if (take_o) begin
        a_q <= a_d; f_q <= f_d; bc_q <= bc_d; de_q <= de_d;
        hl_q <= hl_d; sp_q <= sp_d; pc_q <= pc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

endmodule

@@ sv/sm83_checker.sv @@
// ----------------------------------------------------------------------------
// sm83_checker
// Port-level checks for the execute subset block.
// ----------------------------------------------------------------------------
module sm83_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input sm83_pkg::out_item_t res_o
);

  a_low_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> res_o.reg_af[3:0] == 4'h0) else $error("flag low nibble not zero");

  a_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.mem_read && !res_o.mem_write) |-> res_o.mem_addr == 16'h0)
    else $error("address without access");

  a_wdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.mem_write) |-> res_o.write_data == 8'h0)
    else $error("write data without write");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty && $stable(res_o)) else $error("result dropped");

  // The input queue only fills up behind a waiting result.
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty) else $error("full with no result waiting");

endmodule

bind sm83_cpu_execute_subset_top sm83_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .res_o  (res_o)
);
